// File: sv/entropic_softmin_column_lse_defines.svh
// assertion macros shared by the column log-sum-exp block
`ifndef ENTROPIC_SOFTMIN_COLUMN_LSE_DEFINES_SVH
`define ENTROPIC_SOFTMIN_COLUMN_LSE_DEFINES_SVH
`ifndef SYNTHESIS
`define ESL_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
`define ESL_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define ESL_ASSERT_IMP(label, clk, rst, ante, cons, msg)
`define ESL_ASSERT_NXT(label, clk, rst, ante, cons, msg)
`endif
`endif

// File: sv/esl_pkg.sv
package esl_pkg;

  localparam int FRAC_BITS = 16;
  localparam int SUM_WIDTH = 48;
  localparam int QB = 30;
  localparam int POS_W = $clog2(SUM_WIDTH);

  localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;
  localparam logic [29:0] LN2_Q30 = 30'd744261118;
  localparam logic [30:0] Q30_ONE = 31'h40000000;

  // exp argument below 32.0, u = n + fr in q30
  localparam int AW = FRAC_BITS + 5;
  localparam int UW = AW + 31 - FRAC_BITS;
  localparam int NW = UW - QB;
  localparam int EW = FRAC_BITS + 1;
  localparam int LN30_W = POS_W + 31;
  localparam int LN_W = LN30_W - (QB - FRAC_BITS);
  localparam int YW = 34;

  localparam logic [SUM_WIDTH-1:0] ONE_SUM = {{(SUM_WIDTH-1){1'b0}}, 1'b1} << FRAC_BITS;
  localparam logic [EW-1:0] EXP_ONE = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [32:0] EXP_LIMIT = 33'd32 << FRAC_BITS;

  localparam logic [3:0] HORNER_TERMS = 4'd8;
  localparam logic [4:0] SQ_STEPS = 5'd30;

  localparam logic [7:0] REG_EPS = 8'd0;
  localparam logic [7:0] REG_EPS_RECIP = 8'd1;

  typedef logic [4:0] op_t;
  localparam op_t OP_NOP     = 5'd0;
  localparam op_t OP_LOAD    = 5'd1;
  localparam op_t OP_MULX    = 5'd2;
  localparam op_t OP_CLAMPX  = 5'd3;
  localparam op_t OP_DIFF    = 5'd4;
  localparam op_t OP_EXPU    = 5'd5;
  localparam op_t OP_EXPG    = 5'd6;
  localparam op_t OP_HMUL    = 5'd7;
  localparam op_t OP_HDIV    = 5'd8;
  localparam op_t OP_HSUB    = 5'd9;
  localparam op_t OP_ESHIFT  = 5'd10;
  localparam op_t OP_RESCALE = 5'd11;
  localparam op_t OP_ACCUM   = 5'd12;
  localparam op_t OP_NINIT   = 5'd13;
  localparam op_t OP_NORM    = 5'd14;
  localparam op_t OP_SQINIT  = 5'd15;
  localparam op_t OP_SQ      = 5'd16;
  localparam op_t OP_LNA     = 5'd17;
  localparam op_t OP_LNB     = 5'd18;
  localparam op_t OP_FMUL    = 5'd19;
  localparam op_t OP_FOUT    = 5'd20;

  typedef struct packed {
    op_t        op;
    logic [3:0] k;
  } cmd_t;

  typedef struct packed {
    logic started;
    logic last;
    logic norm_done;
    logic out_free;
  } stat_t;

  // floor(2^32 / k), used for the horner divide by the term index
  function automatic logic [32:0] recip_k(input logic [3:0] k);
    logic [32:0] r;
    case (k)
      4'd1: r = 33'h100000000;
      4'd2: r = 33'd2147483648;
      4'd3: r = 33'd1431655765;
      4'd4: r = 33'd1073741824;
      4'd5: r = 33'd858993459;
      4'd6: r = 33'd715827882;
      4'd7: r = 33'd613566756;
      4'd8: r = 33'd536870912;
      default: r = 33'd0;
    endcase
    return r;
  endfunction

endpackage

// File: sv/esl_if.sv
interface esl_in_if;
  logic valid;
  logic ready;
  logic signed [31:0] cost_value;
  logic signed [31:0] dual_potential;
  logic signed [31:0] log_measure;
  logic last_in_column;
  modport source(output valid, cost_value, dual_potential, log_measure, last_in_column,
                 input ready);
  modport sink(input valid, cost_value, dual_potential, log_measure, last_in_column,
               output ready);
endinterface

interface esl_out_if;
  logic valid;
  logic ready;
  logic signed [31:0] softmin_value;
  logic saturated;
  modport source(output valid, softmin_value, saturated, input ready);
  modport sink(input valid, softmin_value, saturated, output ready);
endinterface

interface esl_cfg_if;
  logic valid;
  logic ready;
  logic [7:0] index;
  logic [31:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

// File: sv/esl_ctrl.sv
`include "entropic_softmin_column_lse_defines.svh"

module esl_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  esl_pkg::stat_t  stat,
  output esl_pkg::cmd_t   cmd
);

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_X1   = 5'd1;
  localparam logic [4:0] S_X2   = 5'd2;
  localparam logic [4:0] S_D    = 5'd3;
  localparam logic [4:0] S_E1   = 5'd4;
  localparam logic [4:0] S_E2   = 5'd5;
  localparam logic [4:0] S_H1   = 5'd6;
  localparam logic [4:0] S_H2   = 5'd7;
  localparam logic [4:0] S_H3   = 5'd8;
  localparam logic [4:0] S_ESH  = 5'd9;
  localparam logic [4:0] S_A1   = 5'd10;
  localparam logic [4:0] S_A2   = 5'd11;
  localparam logic [4:0] S_CHK  = 5'd12;
  localparam logic [4:0] S_NI   = 5'd13;
  localparam logic [4:0] S_NORM = 5'd14;
  localparam logic [4:0] S_SQI  = 5'd15;
  localparam logic [4:0] S_SQ   = 5'd16;
  localparam logic [4:0] S_LA   = 5'd17;
  localparam logic [4:0] S_LB   = 5'd18;
  localparam logic [4:0] S_FM   = 5'd19;
  localparam logic [4:0] S_FO   = 5'd20;

  logic [4:0] state, state_next;
  logic [3:0] k, k_next;
  logic [4:0] sq_cnt, sq_cnt_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    k_next = k;
    sq_cnt_next = sq_cnt;
    cmd.k = k;
    cmd.op = esl_pkg::OP_NOP;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op = esl_pkg::OP_LOAD;
          state_next = S_X1;
        end
      end
      S_X1: begin
        cmd.op = esl_pkg::OP_MULX;
        state_next = S_X2;
      end
      S_X2: begin
        cmd.op = esl_pkg::OP_CLAMPX;
        state_next = S_D;
      end
      S_D: begin
        cmd.op = esl_pkg::OP_DIFF;
        state_next = stat.started ? S_E1 : S_CHK;
      end
      S_E1: begin
        cmd.op = esl_pkg::OP_EXPU;
        state_next = S_E2;
      end
      S_E2: begin
        cmd.op = esl_pkg::OP_EXPG;
        k_next = esl_pkg::HORNER_TERMS;
        state_next = S_H1;
      end
      S_H1: begin
        cmd.op = esl_pkg::OP_HMUL;
        state_next = S_H2;
      end
      S_H2: begin
        cmd.op = esl_pkg::OP_HDIV;
        state_next = S_H3;
      end
      S_H3: begin
        cmd.op = esl_pkg::OP_HSUB;
        k_next = k - 4'd1;
        state_next = (k == 4'd1) ? S_ESH : S_H1;
      end
      S_ESH: begin
        cmd.op = esl_pkg::OP_ESHIFT;
        state_next = S_A1;
      end
      S_A1: begin
        cmd.op = esl_pkg::OP_RESCALE;
        state_next = S_A2;
      end
      S_A2: begin
        cmd.op = esl_pkg::OP_ACCUM;
        state_next = S_CHK;
      end
      S_CHK: begin
        state_next = stat.last ? S_NI : S_IDLE;
      end
      S_NI: begin
        cmd.op = esl_pkg::OP_NINIT;
        state_next = S_NORM;
      end
      S_NORM: begin
        cmd.op = esl_pkg::OP_NORM;
        if (stat.norm_done) begin
          state_next = S_SQI;
        end
      end
      S_SQI: begin
        cmd.op = esl_pkg::OP_SQINIT;
        sq_cnt_next = esl_pkg::SQ_STEPS;
        state_next = S_SQ;
      end
      S_SQ: begin
        cmd.op = esl_pkg::OP_SQ;
        sq_cnt_next = sq_cnt - 5'd1;
        state_next = (sq_cnt == 5'd1) ? S_LA : S_SQ;
      end
      S_LA: begin
        cmd.op = esl_pkg::OP_LNA;
        state_next = S_LB;
      end
      S_LB: begin
        cmd.op = esl_pkg::OP_LNB;
        state_next = S_FM;
      end
      S_FM: begin
        cmd.op = esl_pkg::OP_FMUL;
        state_next = S_FO;
      end
      S_FO: begin
        cmd.op = esl_pkg::OP_FOUT;
        if (stat.out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      k <= 4'd0;
      sq_cnt <= 5'd0;
    end else begin
      state <= state_next;
      k <= k_next;
      sq_cnt <= sq_cnt_next;
    end
  end

  `ESL_ASSERT_NXT(a_load_starts, clk, rst, in_valid && in_ready, state == S_X1, "accepted beat did not start")
  `ESL_ASSERT_IMP(a_k_range, clk, rst, state == S_H1 || state == S_H2 || state == S_H3, k != 4'd0 && k <= esl_pkg::HORNER_TERMS, "horner index out of range")
  `ESL_ASSERT_IMP(a_sq_cnt, clk, rst, state == S_SQ, sq_cnt != 5'd0, "squaring count ran out")
  `ESL_ASSERT_NXT(a_out_done, clk, rst, state == S_FO && stat.out_free, state == S_IDLE, "result store did not finish")

endmodule

// File: sv/esl_dp.sv
module esl_dp (
  input  logic                clk,
  input  logic                rst,
  input  esl_pkg::cmd_t       cmd,
  output esl_pkg::stat_t      stat,
  input  logic signed [31:0]  cost_value,
  input  logic signed [31:0]  dual_potential,
  input  logic signed [31:0]  log_measure,
  input  logic                last_in_column,
  input  logic                cfg_valid,
  input  logic [7:0]          cfg_index,
  input  logic [31:0]         cfg_data,
  output logic signed [31:0]  softmin_value,
  output logic                saturated,
  output logic                out_valid,
  input  logic                out_ready
);

  localparam int F = esl_pkg::FRAC_BITS;
  localparam int SW = esl_pkg::SUM_WIDTH;
  localparam int QB = esl_pkg::QB;
  localparam int AW = esl_pkg::AW;
  localparam int UW = esl_pkg::UW;
  localparam int NW = esl_pkg::NW;
  localparam int EW = esl_pkg::EW;
  localparam int PW = esl_pkg::POS_W;
  localparam int L30 = esl_pkg::LN30_W;
  localparam int LW = esl_pkg::LN_W;
  localparam int YW = esl_pkg::YW;

  // config
  logic [30:0] eps, eps_recip;

  // architectural state
  logic signed [31:0] run_max;
  logic [SW-1:0] run_sum;
  logic started, ovf;

  // working registers
  logic signed [31:0] m_r, x_r;
  logic last_r;
  logic signed [32:0] diff_r;
  logic signed [64:0] prodx_r;
  logic [32:0] a_r;
  logic gt_r, big_r, zero_r;
  logic [UW-1:0] u_r;
  logic [NW-1:0] n_r;
  logic [29:0] g_r;
  logic [30:0] r_r;
  logic [60:0] hp_r;
  logic [30:0] q_r;
  logic [31:0] est_r;
  logic [EW-1:0] e_r;
  logic [SW-1:0] rs_r, addb_r;
  logic [SW-1:0] nm;
  logic [PW-1:0] pos;
  logic [30:0] mm;
  logic [29:0] frac;
  logic [PW+29:0] pl_r;
  logic [29:0] fl_r;
  logic [LW-1:0] ln_r;
  logic signed [YW+31:0] fp_r;

  // datapath logic
  logic signed [64:0] prodx_c, x_w;
  logic x_ovf;
  logic signed [31:0] x_cl;
  logic signed [32:0] dx;
  logic [AW+30:0] up;
  logic [59:0] gp;
  logic [63:0] hd;
  logic [35:0] ek, rem;
  logic [31:0] quo;
  logic [6:0] sh;
  logic [63:0] rnd, rr;
  logic [SW:0] hi;
  logic [F+EW-1:0] lo;
  logic [SW:0] rs_c, tot;
  logic [61:0] sq;
  logic [31:0] s2;
  logic [PW-1:0] pos_off;
  logic [59:0] flp;
  logic [L30-1:0] ln30;
  logic signed [YW-1:0] y;
  logic signed [YW+31:0] fp_c, yy;
  logic y_ovf;
  logic signed [31:0] y_cl;
  logic out_free;

  assign out_free = !out_valid || out_ready;
  assign stat.started = started;
  assign stat.last = last_r;
  assign stat.norm_done = nm[SW-1];
  assign stat.out_free = out_free;

  always_comb begin
    prodx_c = 65'(diff_r) * 65'($signed({1'b0, eps_recip}));
    x_w = (prodx_r >>> F) + 65'(m_r);
    x_ovf = !((&x_w[64:31]) || !(|x_w[64:31]));
    x_cl = x_ovf ? (x_w[64] ? 32'sh80000000 : 32'sh7fffffff) : x_w[31:0];
    dx = {x_r[31], x_r} - {run_max[31], run_max};
    up = (AW + 31)'(a_r[AW-1:0]) * (AW + 31)'(esl_pkg::LOG2E_Q30);
    gp = 60'(u_r[QB-1:0]) * 60'(esl_pkg::LN2_Q30);
    hd = 64'(hp_r[60:30]) * 64'(esl_pkg::recip_k(cmd.k));
    ek = 36'(est_r) * 36'(cmd.k);
    rem = 36'(q_r) - ek;
    quo = (rem >= 36'(cmd.k)) ? est_r + 32'd1 : est_r;
    sh = 7'(QB - F) + 7'(n_r);
    rnd = 64'(r_r) + (64'd1 << (sh - 7'd1));
    rr = rnd >> sh;
    hi = (SW + 1)'(run_sum[SW-1:F]) * (SW + 1)'(e_r);
    lo = (F + EW)'(run_sum[F-1:0]) * (F + EW)'(e_r);
    rs_c = hi + (SW + 1)'(lo >> F);
    tot = {1'b0, rs_r} + {1'b0, addb_r};
    sq = 62'(mm) * 62'(mm);
    s2 = sq[61:30];
    pos_off = pos - PW'(F);
    flp = 60'(frac) * 60'(esl_pkg::LN2_Q30);
    ln30 = L30'(pl_r) + L30'(fl_r) + (L30'(1) << (QB - 1 - F));
    y = $signed(YW'(ln_r)) + $signed({{(YW-32){run_max[31]}}, run_max});
    fp_c = (YW + 32)'(y) * (YW + 32)'($signed({1'b0, eps}));
    yy = fp_r >>> F;
    y_ovf = !((&yy[YW+31:31]) || !(|yy[YW+31:31]));
    y_cl = y_ovf ? (yy[YW+31] ? 32'sh80000000 : 32'sh7fffffff) : yy[31:0];
  end

  // config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      eps <= 31'd65536;
      eps_recip <= 31'd65536;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        esl_pkg::REG_EPS:       eps <= cfg_data[30:0];
        esl_pkg::REG_EPS_RECIP: eps_recip <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  // control-like state
  always_ff @(posedge clk) begin
    if (rst) begin
      run_max <= 32'sd0;
      run_sum <= '0;
      started <= 1'b0;
      ovf <= 1'b0;
      out_valid <= 1'b0;
      last_r <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (cmd.op)
        esl_pkg::OP_LOAD: last_r <= last_in_column;
        esl_pkg::OP_CLAMPX: begin
          if (x_ovf) begin
            ovf <= 1'b1;
          end
        end
        esl_pkg::OP_DIFF: begin
          if (!started) begin
            run_max <= x_r;
            run_sum <= esl_pkg::ONE_SUM;
            started <= 1'b1;
          end
        end
        esl_pkg::OP_ACCUM: begin
          if (tot[SW]) begin
            run_sum <= '1;
            ovf <= 1'b1;
          end else begin
            run_sum <= tot[SW-1:0];
          end
          if (gt_r) begin
            run_max <= x_r;
          end
        end
        esl_pkg::OP_FOUT: begin
          if (out_free) begin
            out_valid <= 1'b1;
            run_max <= 32'sd0;
            run_sum <= '0;
            started <= 1'b0;
            ovf <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      esl_pkg::OP_LOAD: begin
        m_r <= log_measure;
        diff_r <= {dual_potential[31], dual_potential} - {cost_value[31], cost_value};
      end
      esl_pkg::OP_MULX: prodx_r <= prodx_c;
      esl_pkg::OP_CLAMPX: x_r <= x_cl;
      esl_pkg::OP_DIFF: begin
        gt_r <= !dx[32] && (dx != 33'sd0);
        a_r <= dx[32] ? 33'(-dx) : 33'(dx);
      end
      esl_pkg::OP_EXPU: begin
        u_r <= up[AW+30:F];
        big_r <= (a_r >= esl_pkg::EXP_LIMIT);
        zero_r <= (a_r == 33'd0);
      end
      esl_pkg::OP_EXPG: begin
        g_r <= gp[59:30];
        n_r <= u_r[UW-1:QB];
        r_r <= esl_pkg::Q30_ONE;
      end
      esl_pkg::OP_HMUL: hp_r <= 61'(g_r) * 61'(r_r);
      esl_pkg::OP_HDIV: begin
        q_r <= hp_r[60:30];
        est_r <= hd[63:32];
      end
      esl_pkg::OP_HSUB: r_r <= esl_pkg::Q30_ONE - quo[30:0];
      esl_pkg::OP_ESHIFT: begin
        if (big_r) begin
          e_r <= '0;
        end else if (zero_r) begin
          e_r <= esl_pkg::EXP_ONE;
        end else begin
          e_r <= rr[EW-1:0];
        end
      end
      esl_pkg::OP_RESCALE: begin
        if (gt_r) begin
          rs_r <= rs_c[SW-1:0];
          addb_r <= esl_pkg::ONE_SUM;
        end else begin
          rs_r <= run_sum;
          addb_r <= SW'(e_r);
        end
      end
      esl_pkg::OP_NINIT: begin
        nm <= (run_sum < esl_pkg::ONE_SUM) ? esl_pkg::ONE_SUM : run_sum;
        pos <= PW'(SW - 1);
      end
      esl_pkg::OP_NORM: begin
        if (!nm[SW-1]) begin
          nm <= nm << 1;
          pos <= pos - PW'(1);
        end
      end
      esl_pkg::OP_SQINIT: begin
        mm <= nm[SW-1 -: 31];
        frac <= '0;
      end
      esl_pkg::OP_SQ: begin
        if (s2[31]) begin
          mm <= s2[31:1];
          frac <= {frac[28:0], 1'b1};
        end else begin
          mm <= s2[30:0];
          frac <= {frac[28:0], 1'b0};
        end
      end
      esl_pkg::OP_LNA: begin
        pl_r <= (PW + 30)'(pos_off) * (PW + 30)'(esl_pkg::LN2_Q30);
        fl_r <= flp[59:30];
      end
      esl_pkg::OP_LNB: ln_r <= ln30[L30-1:QB-F];
      esl_pkg::OP_FMUL: fp_r <= fp_c;
      esl_pkg::OP_FOUT: begin
        if (out_free) begin
          softmin_value <= y_cl;
          saturated <= y_ovf || ovf;
        end
      end
      default: ;
    endcase
  end

endmodule

// File: sv/entropic_softmin_column_lse.sv
// first element of a column: accept, x, then ready again; later elements also run
// the 8-term exp series, a multiply, divide and subtract per term, then rescale and accumulate
// an element marked last adds a leading-one search one bit per cycle,
// then 30 squaring steps of the log unit, then the eps multiply and result store
// one element at a time, accepted only while idle; one result per column, held in an output register
// reset (rst, synchronous, active high): column state cleared, eps and 1/eps set to 1.0
module entropic_softmin_column_lse (
  input logic clk,
  input logic rst,
  esl_in_if.sink   din,
  esl_out_if.source dout,
  esl_cfg_if.sink  cfg
);

  // command and status between sequencer and datapath
  esl_pkg::cmd_t  cmd;
  esl_pkg::stat_t stat;
  logic in_ready;

  // config writes always land at once
  assign cfg.ready = 1'b1;
  assign din.ready = in_ready;

  // sequencer: accept, x, then exp series and accumulate past the first element, then log and scale on the last beat
  esl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (din.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // datapath: running max and rescaled sum, exp and log units, output register
  esl_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .cost_value     (din.cost_value),
    .dual_potential (din.dual_potential),
    .log_measure    (din.log_measure),
    .last_in_column (din.last_in_column),
    .cfg_valid      (cfg.valid),
    .cfg_index      (cfg.index),
    .cfg_data       (cfg.data),
    .softmin_value  (dout.softmin_value),
    .saturated      (dout.saturated),
    .out_valid      (dout.valid),
    .out_ready      (dout.ready)
  );

endmodule
